// ===== sv/mpd_pkg.sv =====
// Shared types and constants for the marker packet deframer.
package mpd_pkg;

	localparam int DATA_W      = 8;
	localparam int MIN_FILL_W  = 6;
	localparam int INDEX_W     = 5;
	localparam int MAX_RESULTS = 32;
	localparam int CFG_IDX_W   = 2;

	localparam logic [DATA_W-1:0]     START_RST    = 8'd42;
	localparam logic [DATA_W-1:0]     END_RST      = 8'd35;
	localparam logic [MIN_FILL_W-1:0] MIN_FILL_RST = 6'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MARKER = 2'd0,
		REG_END_MARKER   = 2'd1,
		REG_MIN_FILL     = 2'd2
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SRD  = 7'b0000010,
		ST_SCMP = 7'b0000100,
		ST_ERD  = 7'b0001000,
		ST_ELD  = 7'b0010000,
		ST_EOUT = 7'b0100000,
		ST_SPARE = 7'b1000000
	} state_t;

endpackage

// ===== sv/mpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/marker_packet_deframer_unit.sv =====
// Marker packet deframer top level: circular byte buffer, marker search and packet output.
// Steps: an accepted end marker starts a search back from the newest byte (SRD, SCMP) until
// the start marker is found or every held byte has been read; each packet word is then read,
// loaded and offered (ERD, ELD, EOUT), and held in EOUT while the output stalls. No input
// byte is taken while a search or a packet is under way.
// Reset clears the fill count and loads the marker defaults; buffer contents stay unknown.
module marker_packet_deframer_unit #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] packet_byte, [12:8] byte_index, [15:13] zero
	output logic        m_tlast,   // last_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int AW   = $clog2(BUFFER_DEPTH);
	localparam int CW   = $clog2(BUFFER_DEPTH + 1);
	localparam int CMPW = (CW > mpd_pkg::MIN_FILL_W) ? CW : mpd_pkg::MIN_FILL_W;

	mpd_pkg::state_t state_q;

	logic [mpd_pkg::DATA_W-1:0]     start_q;
	logic [mpd_pkg::DATA_W-1:0]     end_q;
	logic [mpd_pkg::MIN_FILL_W-1:0] min_fill_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] newest_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] cnt_q;
	logic [mpd_pkg::DATA_W-1:0] out_q;

	logic                       accept;
	logic                       full;
	logic [AW:0]                tail_sum;
	logic [AW-1:0]              tail;
	logic [CW-1:0]              fill_next;
	logic                       hit_end;
	logic [mpd_pkg::DATA_W-1:0] rdata;
	logic [AW-1:0]              lastk;
	logic [AW:0]                first_sum;
	logic [AW-1:0]              first_addr;
	logic                       search_done;
	logic [31:0]                idx_ext;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(BUFFER_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(BUFFER_DEPTH - 1) : p - AW'(1);
	endfunction

	assign s_tready  = (state_q == mpd_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	assign full      = (fill_q == CW'(BUFFER_DEPTH));
	assign tail_sum  = (AW+1)'(head_q) + (AW+1)'(fill_q);
	assign tail      = (tail_sum >= (AW+1)'(BUFFER_DEPTH)) ?
	                   AW'(tail_sum - (AW+1)'(BUFFER_DEPTH)) : AW'(tail_sum);
	assign fill_next = full ? fill_q : fill_q + CW'(1);
	assign hit_end   = (CMPW'(fill_next) >= CMPW'(min_fill_q)) && (s_tdata == end_q);

	assign lastk      = (32'(k_q) > 32'(mpd_pkg::MAX_RESULTS - 1)) ?
	                    AW'(mpd_pkg::MAX_RESULTS - 1) : k_q;
	assign first_sum  = (AW+1)'(newest_q) + (AW+1)'(BUFFER_DEPTH) - (AW+1)'(lastk);
	assign first_addr = (first_sum >= (AW+1)'(BUFFER_DEPTH)) ?
	                    AW'(first_sum - (AW+1)'(BUFFER_DEPTH)) : AW'(first_sum);
	assign search_done = ((CW'(k_q) + CW'(1)) == fill_q);

	mpd_ram #(
		.WIDTH(mpd_pkg::DATA_W),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(tail),
		.wdata(s_tdata),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= mpd_pkg::START_RST;
			end_q      <= mpd_pkg::END_RST;
			min_fill_q <= mpd_pkg::MIN_FILL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mpd_pkg::REG_START_MARKER: start_q <= cfg_data;
				mpd_pkg::REG_END_MARKER:   end_q <= cfg_data;
				mpd_pkg::REG_MIN_FILL:     min_fill_q <= cfg_data[mpd_pkg::MIN_FILL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpd_pkg::ST_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				mpd_pkg::ST_IDLE: begin
					if (accept) begin
						fill_q <= fill_next;
						if (full) begin
							head_q <= ptr_inc(head_q);
						end
						if (hit_end) begin
							state_q <= mpd_pkg::ST_SRD;
						end
					end
				end
				mpd_pkg::ST_SRD: begin
					state_q <= mpd_pkg::ST_SCMP;
				end
				mpd_pkg::ST_SCMP: begin
					if (rdata == start_q) begin
						state_q <= mpd_pkg::ST_ERD;
					end else if (search_done) begin
						state_q <= mpd_pkg::ST_IDLE;
					end else begin
						state_q <= mpd_pkg::ST_SRD;
					end
				end
				mpd_pkg::ST_ERD: begin
					state_q <= mpd_pkg::ST_ELD;
				end
				mpd_pkg::ST_ELD: begin
					state_q <= mpd_pkg::ST_EOUT;
				end
				mpd_pkg::ST_EOUT: begin
					if (m_tready) begin
						if (cnt_q == last_q) begin
							fill_q  <= '0;
							state_q <= mpd_pkg::ST_IDLE;
						end else begin
							state_q <= mpd_pkg::ST_ERD;
						end
					end
				end
				default: state_q <= mpd_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mpd_pkg::ST_IDLE: begin
				newest_q <= tail;
				ptr_q    <= tail;
				k_q      <= '0;
			end
			mpd_pkg::ST_SCMP: begin
				if (rdata == start_q) begin
					ptr_q  <= first_addr;
					last_q <= lastk;
					cnt_q  <= '0;
				end else begin
					ptr_q <= ptr_dec(ptr_q);
					k_q   <= k_q + AW'(1);
				end
			end
			mpd_pkg::ST_ELD: begin
				out_q <= rdata;
			end
			mpd_pkg::ST_EOUT: begin
				if (m_tready) begin
					ptr_q <= ptr_inc(ptr_q);
					cnt_q <= cnt_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	assign idx_ext  = 32'(cnt_q);
	assign m_tvalid = (state_q == mpd_pkg::ST_EOUT);
	assign m_tlast  = (cnt_q == last_q);
	assign m_tdata  = {3'b000, idx_ext[mpd_pkg::INDEX_W-1:0], out_q};

endmodule

// ===== sv/mpd_checker.sv =====
// Port-level checks for the marker packet deframer, bound to the top level.
module mpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// Never take a word while one is offered on the output.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while output word pending");

	// Hold a stalled output word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

	// Stay busy inside a packet.
	a_busy_in_packet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !s_tready)
		else $error("input reopened inside a packet");

	// Return to idle after the last word.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("not idle after packet end");

endmodule

bind marker_packet_deframer_unit mpd_checker u_mpd_checker (.*);

// ===== tb/mpd_checker.sv =====
// Checker for the marker packet deframer: tracks the channels, predicts packets and compares.
module mpd_tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatch_count,
	output int          words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 32;
	localparam int DW = mpd_pkg::DATA_W;
	localparam int IW = mpd_pkg::INDEX_W;

	typedef struct packed {
		logic [DW-1:0] data;
		logic [IW-1:0] index;
		logic          last;
	} packet_word_t;

	logic [DW-1:0]                  held_bytes [STORE_DEPTH];
	int                             held_count;
	logic [DW-1:0]                  open_marker;
	logic [DW-1:0]                  close_marker;
	logic [mpd_pkg::MIN_FILL_W-1:0] fill_threshold;
	packet_word_t                   packet_words [$];
	int                             errors;

	function automatic void deframe_byte(input logic [DW-1:0] rx);
		int start_pos;
		int k;
		packet_word_t w;
		start_pos = -1;
		if (held_count < STORE_DEPTH) begin
			held_bytes[held_count] = rx;
			held_count++;
		end else begin
			for (k = 0; k < STORE_DEPTH - 1; k++)
				held_bytes[k] = held_bytes[k + 1];
			held_bytes[STORE_DEPTH - 1] = rx;
		end
		if (held_count < int'(fill_threshold) || rx != close_marker)
			return;
		for (k = held_count - 1; k >= 0 && start_pos < 0; k--)
			if (held_bytes[k] == open_marker)
				start_pos = k;
		if (start_pos < 0)
			return;
		for (k = start_pos; k < held_count; k++) begin
			w.data  = held_bytes[k];
			w.index = IW'(k - start_pos);
			w.last  = (k == held_count - 1);
			packet_words.push_back(w);
		end
		held_count = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		packet_word_t w;
		if (!arst_n) begin
			held_count     = 0;
			open_marker    = mpd_pkg::START_RST;
			close_marker   = mpd_pkg::END_RST;
			fill_threshold = mpd_pkg::MIN_FILL_RST;
			errors         = 0;
			packet_words.delete();
			mismatch_count <= 0;
			words_pending  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mpd_pkg::REG_START_MARKER: open_marker = cfg_data;
					mpd_pkg::REG_END_MARKER:   close_marker = cfg_data;
					mpd_pkg::REG_MIN_FILL:
						fill_threshold = cfg_data[mpd_pkg::MIN_FILL_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (packet_words.size() == 0) begin
					$error("unexpected word: packet_byte %0h byte_index %0d last_byte %0b",
						m_tdata[DW-1:0], m_tdata[DW+IW-1:DW], m_tlast);
					errors++;
				end else begin
					w = packet_words.pop_front();
					if (m_tdata[DW-1:0] !== w.data) begin
						$error("packet_byte: expected %0h, actual %0h",
							w.data, m_tdata[DW-1:0]);
						errors++;
					end
					if (m_tdata[DW+IW-1:DW] !== w.index) begin
						$error("byte_index: expected %0d, actual %0d",
							w.index, m_tdata[DW+IW-1:DW]);
						errors++;
					end
					if (m_tlast !== w.last) begin
						$error("last_byte: expected %0b, actual %0b", w.last, m_tlast);
						errors++;
					end
				end
			end
			mismatch_count <= errors;
			words_pending  <= packet_words.size();
		end
	end

endmodule

// ===== tb/tb_marker_packet_deframer_unit.sv =====
// Testbench top for the marker packet deframer: stimulus, idling, pressure and verdict.
module tb_marker_packet_deframer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [mpd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 80;
	localparam int STUCK_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 400;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [7:0]  cfg_data  = 8'h00;

	int   mismatch_count;
	int   words_pending;
	logic gaps_on     = 1'b1;
	int   rx_hold     = 0;
	int   stuck_cycles = 0;
	int   bytes_sent  = 0;
	logic [7:0] open_byte  = mpd_pkg::START_RST;
	logic [7:0] close_byte = mpd_pkg::END_RST;

	marker_packet_deframer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mpd_tb_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.words_pending  (words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold  <= rx_hold - 1;
			end else begin
				m_tready <= !(gaps_on && $urandom_range(99) < 38);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] value);
		while (gaps_on && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// hold the sender until every packet word is out, then let the block settle
	task automatic drain_words();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
		drain_words();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			mpd_pkg::REG_START_MARKER: open_byte = value;
			mpd_pkg::REG_END_MARKER:   close_byte = value;
			default: ;
		endcase
	endtask

	initial begin : stimulus
		int phase;
		int budget;
		int kind;
		int junk;
		int body;
		int fill_min;
		logic [7:0] sm;
		logic [7:0] em;
		wait (arst_n === 1'b1);
		@(posedge clk);

		send_byte(8'h2A); send_byte(8'h41); send_byte(8'h42); send_byte(8'h23);
		send_byte(8'h00); send_byte(8'hFF); send_byte(8'h23);
		send_byte(8'h2A); send_byte(8'h23);
		cfg_write(REG_UNUSED, 8'hA5);
		cfg_write(mpd_pkg::REG_START_MARKER, 8'h7E);
		cfg_write(mpd_pkg::REG_END_MARKER, 8'h7E);
		send_byte(8'h55); send_byte(8'hAA); send_byte(8'h7E);
		cfg_write(mpd_pkg::REG_MIN_FILL, 8'hC0);
		send_byte(8'h7E);
		cfg_write(mpd_pkg::REG_START_MARKER, 8'h00);
		cfg_write(mpd_pkg::REG_END_MARKER, 8'hFF);
		cfg_write(mpd_pkg::REG_MIN_FILL, 8'h21);
		send_byte(8'h00); send_byte(8'h01); send_byte(8'hFF);

		for (phase = 0; phase < 8; phase++) begin
			sm       = 8'($urandom_range(255));
			em       = 8'($urandom_range(255));
			fill_min = $urandom_range(1, 8);
			budget   = 25;
			case (phase)
				0: begin sm = 8'h00; em = 8'hFF; fill_min = 1; end
				1: begin sm = 8'hFF; em = 8'h00; fill_min = 32; end
				2: begin fill_min = 63; budget = 12; end
				3: begin em = sm; fill_min = $urandom_range(1, 4); end
				5: fill_min = 2;
				6: fill_min = 20;
				default: ;
			endcase
			cfg_write(mpd_pkg::REG_START_MARKER, sm);
			cfg_write(mpd_pkg::REG_END_MARKER, em);
			cfg_write(mpd_pkg::REG_MIN_FILL, 8'(fill_min));
			if (phase == 5) begin
				gaps_on <= 1'b0;
				rx_hold <= HOLD_CYCLES;
				send_byte(open_byte);
				send_byte(close_byte);
			end
			budget = bytes_sent + budget;
			while (bytes_sent < budget) begin
				kind = $urandom_range(9);
				junk = (fill_min >= 20) ? $urandom_range(18, 32) : $urandom_range(0, 5);
				if ($urandom_range(11) == 0)
					junk = $urandom_range(25, 40);
				body = $urandom_range(0, 8);
				if ($urandom_range(15) == 0)
					body = $urandom_range(24, 34);
				repeat (junk) send_byte(8'($urandom_range(255)));
				if (kind >= 2)
					send_byte(open_byte);
				if (kind >= 2)
					repeat (body) send_byte(8'($urandom_range(255)));
				if (kind != 0 && kind != 2)
					send_byte(close_byte);
			end
			if (phase == 5)
				gaps_on <= 1'b1;
		end

		drain_words();
		if (mismatch_count == 0 && words_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
